### rtl/prs80_pkg.sv
// ----------------------------------------------------------------------------
// prs80_pkg
// Types, constants and round functions for the PRESENT-80 encrypt pipeline.
// ----------------------------------------------------------------------------
package prs80_pkg;

  localparam int BLOCK_W     = 64;
  localparam int KEY_W       = 80;
  localparam int KEY_HIGH_W  = 16;
  localparam int RND_W       = 5;
  localparam int CFG_INDEX_W = 8;

  typedef logic [BLOCK_W-1:0]     block_t;
  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [KEY_HIGH_W-1:0]  key_high_t;
  typedef logic [RND_W-1:0]       rnd_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_KEY_LOW  = 8'd0;
  localparam cfg_index_t REG_KEY_HIGH = 8'd1;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  function automatic block_t sub_layer(block_t s);
    block_t r;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = SBOX[s[4*n +: 4]];
    end
    return r;
  endfunction

  // bit b moves to 16*(b mod 4) + b/4; bit 63 stays put
  function automatic block_t perm_layer(block_t s);
    block_t     r;
    logic [5:0] src;
    logic [5:0] dst;
    for (int b = 0; b < BLOCK_W; b++) begin
      src = 6'(b);
      dst = {src[1:0], src[5:2]};
      r[dst] = s[src];
    end
    return r;
  endfunction

  function automatic block_t round_key(key_t k);
    return k[KEY_W-1 -: BLOCK_W];
  endfunction

  function automatic key_t key_update(key_t k, rnd_t rnd);
    key_t n;
    n = {k[18:0], k[KEY_W-1:19]};
    n[KEY_W-1 -: 4] = SBOX[n[KEY_W-1 -: 4]];
    n[19:15] = n[19:15] ^ rnd;
    return n;
  endfunction

endpackage

### rtl/present80_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// present80_block_encrypt_top
// PRESENT-80 block encryption, fully unrolled, one round per pipeline stage.
// ----------------------------------------------------------------------------
// A block is taken at every clock edge with start high and busy low, so one
// block per cycle is sustained; busy is high only during reset and until the
// first clock edge with rst low. done and the ciphertext are registered
// together in the output register, which holds the final key addition;
// before it lie one input register and ROUND_COUNT-1 round stages. The
// receiver cannot stall, so done is a one-cycle strobe. The key schedule
// travels down the pipe with each block, so the key may only be changed
// while no blocks are in flight.
module present80_block_encrypt_top #(
  parameter int ROUND_COUNT = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  prs80_pkg::block_t        plaintext,
  output logic                     done,
  output prs80_pkg::block_t        ciphertext,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  prs80_pkg::cfg_index_t    cfg_index,
  input  logic [63:0]              cfg_data
);

  prs80_pkg::block_t    key_low;
  prs80_pkg::key_high_t key_high;

  prs80_pkg::block_t state_q [ROUND_COUNT];
  prs80_pkg::key_t   key_q   [ROUND_COUNT];
  logic              valid_q [ROUND_COUNT];

  logic accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        prs80_pkg::REG_KEY_LOW:  key_low  <= cfg_data;
        prs80_pkg::REG_KEY_HIGH: key_high <= cfg_data[prs80_pkg::KEY_HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      state_q[0] <= plaintext;
      key_q[0]   <= {key_high, key_low};
    end
  end

  // round stages; stage k holds the result of round k
  for (genvar k = 1; k < ROUND_COUNT; k++) begin : g_round
    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (valid_q[k-1]) begin
        state_q[k] <= prs80_pkg::perm_layer(prs80_pkg::sub_layer(
                        state_q[k-1] ^ prs80_pkg::round_key(key_q[k-1])));
        key_q[k]   <= prs80_pkg::key_update(key_q[k-1], prs80_pkg::rnd_t'(k));
      end
    end
  end

  // final key addition into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_q[ROUND_COUNT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (valid_q[ROUND_COUNT-1]) begin
      ciphertext <= state_q[ROUND_COUNT-1]
                    ^ prs80_pkg::round_key(key_q[ROUND_COUNT-1]);
    end
  end

endmodule

### rtl/prs80_checker.sv
// ----------------------------------------------------------------------------
// prs80_checker
// Port-level checks for the PRESENT-80 encrypt pipeline.
// ----------------------------------------------------------------------------
module prs80_checker #(
  parameter int ROUND_COUNT = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic                  cfg_valid,
  input logic                  cfg_ready
);

  // every start transfer yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(ROUND_COUNT+1) done)
    else $error("missing result after start transfer");

  // no result without a matching start transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, ROUND_COUNT+1))
    else $error("result without start transfer");

  // the block never blocks input outside reset
  a_not_busy: assert property (@(posedge clk)
    !rst |=> !busy)
    else $error("busy outside reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind present80_block_encrypt_top prs80_checker #(
  .ROUND_COUNT(ROUND_COUNT)
) u_prs80_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
